// ----- src/base64_decoder_custom_alphabet_assert.svh -----
// ----------------------------------------------------------------------------
// Base64 decoder assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef BASE64_DECODER_CUSTOM_ALPHABET_ASSERT_SVH
`define BASE64_DECODER_CUSTOM_ALPHABET_ASSERT_SVH

// same-cycle implication, disabled in reset
`define B64D_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// Base64 decoder package
// Payload types, queue entry type, register indexes and symbol lookup.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic CFG_CUSTOM_ALPHABET = 1'b0;
    localparam logic CFG_OUT_CAPACITY    = 1'b1;

    localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

    localparam logic [7:0] SYM_PAD  = 8'd254;
    localparam logic [7:0] SYM_SKIP = 8'd255;
    localparam logic [2:0] MAX_PADS = 3'd4;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
    localparam logic [7:0] CHAR_HASH    = 8'h23;
    localparam logic [7:0] CHAR_DOLLAR  = 8'h24;

    typedef struct packed {
        logic [7:0] ch;
        logic       char_valid;
        logic       end_of_string;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        is_last;
        logic        status;
        logic [15:0] total_len;
    } t_out;

    typedef struct packed {
        logic [23:0] acc;
        logic [1:0]  nbytes;
        logic        err;
        logic        last;
        logic [15:0] base_len;
    } t_job;

    function automatic logic [7:0] sym_value(input logic [7:0] c, input logic custom);
        logic [7:0] v;
        v = SYM_SKIP;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            v = c - CHAR_UPPER_A;
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            v = c - CHAR_LOWER_A + 8'd26;
        end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            v = c - CHAR_ZERO + 8'd52;
        end else if (c == CHAR_PLUS) begin
            v = 8'd62;
        end else if (c == CHAR_SLASH) begin
            v = 8'd63;
        end else if (c == CHAR_EQUAL) begin
            v = SYM_PAD;
        end else if (custom && c == CHAR_HASH) begin
            v = 8'd62;
        end else if (custom && c == CHAR_DOLLAR) begin
            v = 8'd63;
        end
        return v;
    endfunction

endpackage

// ----- src/b64d_front.sv -----
// ----------------------------------------------------------------------------
// Base64 decoder front end
// Holds configuration and per-string state, classifies each character and
// turns each item into at most one queue entry.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  logic [15:0]     i_cfg_data,
    input  logic            i_accept,
    input  b64d_pkg::t_in   i_in,
    output logic            o_push,
    output b64d_pkg::t_job  o_job
);

    logic        r_custom;
    logic [15:0] r_capacity;
    logic [23:0] r_acc;
    logic [1:0]  r_sym_cnt;
    logic [2:0]  r_pad_cnt;
    logic [15:0] r_bytes;
    logic        r_dropping;

    logic [7:0]  sym;
    logic        is_sym;
    logic        is_pad;
    logic [5:0]  sym6;
    logic [2:0]  n_pad_cnt;
    logic [23:0] n_acc;
    logic        complete;
    logic [1:0]  nb;
    logic [16:0] sum;
    logic        err;
    logic        emit_data;

    always_comb begin
        sym       = b64d_pkg::sym_value(i_in.ch, r_custom);
        is_sym    = i_in.char_valid && !r_dropping && (sym != b64d_pkg::SYM_SKIP);
        is_pad    = (sym == b64d_pkg::SYM_PAD);
        sym6      = is_pad ? 6'd0 : sym[5:0];
        n_pad_cnt = (is_sym && is_pad && r_pad_cnt < b64d_pkg::MAX_PADS)
                    ? r_pad_cnt + 3'd1 : r_pad_cnt;
        n_acc     = {r_acc[17:0], sym6};
        complete  = is_sym && (r_sym_cnt == 2'd3);
        nb        = (n_pad_cnt >= 3'd3) ? 2'd1 : 2'(3'd3 - n_pad_cnt);
        sum       = {1'b0, r_bytes} + {15'd0, nb};
        err       = complete && (n_pad_cnt >= b64d_pkg::MAX_PADS || sum > {1'b0, r_capacity});
        emit_data = complete && !err;
    end

    assign o_push          = i_accept && (err || emit_data || (i_in.end_of_string && !r_dropping));
    assign o_job.acc       = n_acc;
    assign o_job.nbytes    = emit_data ? nb : 2'd0;
    assign o_job.err       = err;
    assign o_job.last      = i_in.end_of_string;
    assign o_job.base_len  = r_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_custom   <= 1'b0;
            r_capacity <= b64d_pkg::CAPACITY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                b64d_pkg::CFG_CUSTOM_ALPHABET: r_custom   <= i_cfg_data[0];
                b64d_pkg::CFG_OUT_CAPACITY:    r_capacity <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_sym_cnt  <= '0;
            r_pad_cnt  <= '0;
            r_bytes    <= '0;
            r_dropping <= 1'b0;
        end else if (i_accept) begin
            if (i_in.end_of_string) begin
                r_acc      <= '0;
                r_sym_cnt  <= '0;
                r_pad_cnt  <= '0;
                r_bytes    <= '0;
                r_dropping <= 1'b0;
            end else if (is_sym) begin
                r_acc     <= complete ? 24'd0 : n_acc;
                r_sym_cnt <= r_sym_cnt + 2'd1;
                r_pad_cnt <= n_pad_cnt;
                if (emit_data) begin
                    r_bytes <= sum[15:0];
                end
                if (err) begin
                    r_dropping <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- src/b64d_queue.sv -----
// ----------------------------------------------------------------------------
// Base64 decoder job queue
// Small FIFO between the front end and the result sequencer.
// ----------------------------------------------------------------------------
module b64d_queue #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b64d_pkg::t_job  i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output b64d_pkg::t_job  o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64d_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ----- src/b64d_back.sv -----
// ----------------------------------------------------------------------------
// Base64 decoder result sequencer
// Expands each queued job into one to three results behind an output register.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  b64d_pkg::t_job  i_job,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output b64d_pkg::t_out  o_out
);

    logic [1:0]     r_k;
    logic           r_out_valid;
    b64d_pkg::t_out r_out;

    logic           load;
    logic           take;
    logic [1:0]     cnt;
    logic           last_k;
    b64d_pkg::t_out res;

    always_comb begin
        load   = !r_out_valid || !i_out_stall;
        take   = load && i_q_valid;
        cnt    = (i_job.err || i_job.nbytes == 2'd0) ? 2'd1 : i_job.nbytes;
        last_k = (r_k == cnt - 2'd1);

        res = '0;
        if (i_job.err) begin
            res.is_last   = 1'b1;
            res.status    = 1'b1;
            res.total_len = i_job.base_len;
        end else if (i_job.nbytes == 2'd0) begin
            res.is_last   = 1'b1;
            res.total_len = i_job.base_len;
        end else begin
            unique case (r_k)
                2'd0:    res.out_byte = i_job.acc[23:16];
                2'd1:    res.out_byte = i_job.acc[15:8];
                default: res.out_byte = i_job.acc[7:0];
            endcase
            res.byte_valid = 1'b1;
            res.is_last    = i_job.last && last_k;
            res.total_len  = i_job.base_len + {14'd0, r_k} + 16'd1;
        end
    end

    assign o_pop       = take && last_k;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= i_q_valid;
            end
            if (take) begin
                r_k <= last_k ? 2'd0 : r_k + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= res;
        end
    end

endmodule

// ----- src/base64_decoder_custom_alphabet.sv -----
// ----------------------------------------------------------------------------
// Base64 decoder with custom alphabet
// Jobs are registered in the job queue, results in the output register.
// Throughput: one character per cycle while the job queue is not full;
// a completed group yields one result per decoded byte; the queue absorbs it.
// Reset: synchronous active low; clears string state, queue and output,
// sets custom_alphabet to 0 and out_capacity to 65535.
// ----------------------------------------------------------------------------
module base64_decoder_custom_alphabet #(
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  logic [15:0]     i_cfg_data,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  b64d_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output b64d_pkg::t_out  o_out
);

    logic           accept;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_valid;
    b64d_pkg::t_job job;
    b64d_pkg::t_job head;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    b64d_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_in       (i_in),
        .o_push     (push),
        .o_job      (job)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    b64d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_job       (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

// ----- src/b64d_checker.sv -----
// ----------------------------------------------------------------------------
// Base64 decoder port checker
// Watches the result channel of the top level.
// ----------------------------------------------------------------------------
`include "base64_decoder_custom_alphabet_assert.svh"

module b64d_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input b64d_pkg::t_out  o_out
);

    `B64D_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out), "stalled result changed")
    `B64D_ASSERT_SAME(a_nodata_last, o_out_valid && !o_out.byte_valid, o_out.is_last && o_out.out_byte == 8'd0, "non-data result not last or byte not zero")
    `B64D_ASSERT_SAME(a_err_nodata, o_out_valid && o_out.status, !o_out.byte_valid, "error result carries data")
    `B64D_ASSERT_SAME(a_data_len, o_out_valid && o_out.byte_valid, o_out.total_len != 16'd0 && !o_out.status, "data result with zero length or error")

endmodule

bind base64_decoder_custom_alphabet b64d_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
